[design/crc_checked_frame_receiver_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the CRC checked frame receiver
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define CRC_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

[design/cfr_pkg.sv]
// ----------------------------------------------------------------------------
// CRC checked frame receiver package
// Frame constants, item codes, parser state codes and the CRC-16/ARC step.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Header as it reads little-endian from the wire: AA CA AC BB.
  localparam logic [31:0] FrameHeader = 32'hBBAC_CAAA;
  localparam logic [15:0] CrcPoly     = 16'hA001;
  localparam logic [15:0] CrcInit     = 16'h0000;
  localparam logic [31:0] MinLen      = 32'd4;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KindFlags = 2'd0,
    KindCmd   = 2'd1,
    KindBody  = 2'd2,
    KindEnd   = 2'd3
  } item_kind_e;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PhHunt    = 4'b0001,
    PhLen     = 4'b0010,
    PhPayload = 4'b0100,
    PhCrc     = 4'b1000
  } phase_e;

  // One result item from the parser.
  typedef struct packed {
    logic       valid;
    item_kind_e kind;
    logic [7:0] data;
    logic       good;
  } cfr_result_t;

  // One byte of reflected CRC-16/ARC.
  function automatic logic [15:0] crc16_arc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // CRC over the four header bytes, evaluated at elaboration.
  function automatic logic [15:0] header_crc();
    logic [15:0] c;
    c = CrcInit;
    for (int k = 0; k < 4; k++) begin
      c = crc16_arc_byte(c, FrameHeader[8*k +: 8]);
    end
    return c;
  endfunction

  localparam logic [15:0] HeaderCrc = header_crc();

endpackage

[design/cfr_deframer.sv]
// ----------------------------------------------------------------------------
// CRC checked frame receiver parser
// Header hunt, length capture, payload tagging and CRC check, one byte a step.
// ----------------------------------------------------------------------------
`include "crc_checked_frame_receiver_macros.svh"

module cfr_deframer
  import cfr_pkg::*;
#(
  parameter int MAX_DATA_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output cfr_result_t result_o
);

  // Payload count holds at most MAX_DATA_LEN - 2.
  localparam int          RemW   = $clog2(MAX_DATA_LEN - 1);
  localparam logic [31:0] MaxLen = 32'(MAX_DATA_LEN);

  phase_e            phase_q, phase_d;
  logic [31:0]       window_q, window_d;
  logic [2:0]        fill_q, fill_d;
  logic [23:0]       len_q, len_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        crc_lo_q, crc_lo_d;
  logic [1:0]        pos_q, pos_d;
  logic [31:0]       len_full;
  logic [31:0]       window_shift;
  logic [15:0]       crc_next;

  assign len_full     = {byte_i, len_q};
  assign window_shift = {byte_i, window_q[31:8]};
  assign crc_next     = crc16_arc_byte(crc_q, byte_i);

  // Next state and result for the byte at hand.
  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    fill_d   = fill_q;
    len_d    = len_q;
    rem_d    = rem_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    pos_d    = pos_q;
    result_o = '0;
    case (phase_q)
      PhHunt: begin
        window_d = window_shift;
        if (fill_q < 3'd4) begin
          fill_d = fill_q + 3'd1;
        end
        if (fill_d >= 3'd4 && window_shift == FrameHeader) begin
          crc_d   = HeaderCrc;
          fill_d  = 3'd0;
          phase_d = PhLen;
        end
      end
      PhLen: begin
        crc_d  = crc_next;
        fill_d = fill_q + 3'd1;
        if (fill_q[1:0] != 2'd3) begin
          len_d[8*fill_q[1:0] +: 8] = byte_i;
        end else if (len_full < MinLen || len_full > MaxLen) begin
          // Bad length: drop the header only and rescan the length bytes.
          window_d = len_full;
          fill_d   = 3'd4;
          phase_d  = PhHunt;
          if (len_full == FrameHeader) begin
            crc_d   = HeaderCrc;
            fill_d  = 3'd0;
            phase_d = PhLen;
          end
        end else begin
          rem_d   = RemW'(len_full[RemW-1:0] - RemW'(2));
          pos_d   = 2'd0;
          fill_d  = 3'd0;
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        crc_d = crc_next;
        rem_d = rem_q - RemW'(1);
        if (pos_q != 2'd2) begin
          pos_d = pos_q + 2'd1;
        end
        if (rem_q == RemW'(1)) begin
          fill_d  = 3'd0;
          phase_d = PhCrc;
        end
        result_o.valid = 1'b1;
        result_o.data  = byte_i;
        case (pos_q)
          2'd0:    result_o.kind = KindFlags;
          2'd1:    result_o.kind = KindCmd;
          default: result_o.kind = KindBody;
        endcase
      end
      PhCrc: begin
        if (fill_q == 3'd0) begin
          crc_lo_d = byte_i;
          fill_d   = 3'd1;
        end else begin
          result_o.valid = 1'b1;
          result_o.kind  = KindEnd;
          result_o.good  = ({byte_i, crc_lo_q} == crc_q);
          window_d       = '0;
          fill_d         = 3'd0;
          phase_d        = PhHunt;
        end
      end
      default: begin
        window_d = '0;
        fill_d   = 3'd0;
        phase_d  = PhHunt;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      window_q <= '0;
      fill_q   <= '0;
      rem_q    <= '0;
      pos_q    <= '0;
      crc_q    <= CrcInit;
    end else if (step_i) begin
      phase_q  <= phase_d;
      window_q <= window_d;
      fill_q   <= fill_d;
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      crc_q    <= crc_d;
    end
  end

  // Captured length and CRC bytes, always written before they are read.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      len_q    <= len_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  `CFR_ASSERT_IMPLY(a_payload_count, clk_i, rst_ni, phase_q == PhPayload, rem_q != '0)
  `CFR_ASSERT_IMPLY(a_len_fill, clk_i, rst_ni, phase_q == PhLen, fill_q < 3'd4)
  `CFR_ASSERT_NEXT(a_end_restarts, clk_i, rst_ni,
      step_i && phase_q == PhCrc && fill_q != 3'd0, phase_q == PhHunt && fill_q == 3'd0)

endmodule

[design/crc_checked_frame_receiver.sv]
// ----------------------------------------------------------------------------
// CRC checked frame receiver
// Deframes a byte stream with header, length and CRC-16/ARC trailer.
// ----------------------------------------------------------------------------
// The receiver takes one byte per cycle while the master side keeps up: each
// byte passes an input register, the parser's combinational update (including
// the unrolled byte-wide CRC step) and an output register, from which its
// result is presented on the master side. Flags, command and
// body bytes are forwarded as they arrive; the second CRC byte yields a frame
// end item whose good flag tells the consumer whether to keep the frame.
// Lengths below 4 or above MAX_DATA_LEN drop only the header and rescan the
// length bytes. Back-pressure on the master side stalls the input only when a
// result is pending and the output register is still occupied.
`include "crc_checked_frame_receiver_macros.svh"

module crc_checked_frame_receiver
  import cfr_pkg::*;
#(
  parameter int MAX_DATA_LEN = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] item_byte
  output logic [2:0] m_axis_tuser    // [1:0] item_kind, [2] frame_good
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  item_kind_e  out_kind_q;
  logic        out_good_q;
  logic        out_free;
  logic        step;
  cfr_result_t res;

  // The held byte moves on unless it makes a result with nowhere to go.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && (!res.valid || out_free);
  assign s_axis_tready = !in_valid_q || step;

  cfr_deframer #(
    .MAX_DATA_LEN(MAX_DATA_LEN)
  ) u_deframer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .result_o(res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_byte_q <= res.data;
      out_kind_q <= res.kind;
      out_good_q <= res.good;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = {out_good_q, out_kind_q};

  `CFR_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, step && res.valid, out_valid_q)
  `CFR_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_valid_q && !step,
      res.valid && out_valid_q && !m_axis_tready)
  `CFR_ASSERT_NEXT(a_input_held, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, in_valid_q)

endmodule
